@@ hdl/crcfc_pkg.sv @@
package crcfc_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [3:0]  MIN_FRAME_LEN = 4'd10;
    localparam logic [3:0]  MAGIC_LEN     = 4'd4;
    localparam logic [3:0]  VERSION_HI    = 4'd4;
    localparam logic [3:0]  VERSION_LO    = 4'd5;

    localparam logic [31:0] MAGIC_RESET   = 32'd1330794820;
    localparam logic [15:0] VERSION_RESET = 16'd1;

    localparam int unsigned PADDR_W = 3;

    typedef enum logic [0:0] {
        REG_MAGIC   = 1'b0,
        REG_VERSION = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_CRC     = 3'd3,
        ST_BAD_VERSION = 3'd4
    } status_t;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       feed_crc;
        logic       magic_bad;
        logic       ver_byte;
        logic       short_frame;
    } req_t;

    // reflected crc-32, one byte, bit at a time
    function automatic logic [31:0] crc_add_byte(input logic [31:0] crc_in,
                                                 input logic [7:0]  byte_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, byte_in};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/crcfc_if.sv @@
interface crcfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface crcfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [31:0] computed_crc;

    modport source (output valid, output frame_status, output computed_crc, input ready);
    modport sink   (input valid, input frame_status, input computed_crc, output ready);
endinterface

@@ hdl/crc32_frame_checker.sv @@
// channel   dir  handshake      payload
// in_ch     in   valid/ready    data_byte[7:0], end_of_frame
// out_ch    out  valid/ready    frame_status[2:0], computed_crc[31:0]
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one byte per cycle sustained while the output is not stalled; the bytewise crc step sits in the back stage
// a result passes through the queue and then the output register after its last byte is taken
// rst_n clears byte count, queue, frame state and result valid; registers
// go to their defaults. a stalled output fills the two-entry queue, after
// which in_ch.ready drops; the output register takes the next result as the
// current one leaves
module crc32_frame_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    crcfc_in_if.sink                            in_ch,
    crcfc_out_if.source                         out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crcfc_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [31:0]     magic_reg;
    logic [31:0]     magic_next;
    logic [15:0]     version_reg;
    logic [15:0]     version_next;
    logic            wr_en;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    crcfc_pkg::req_t front_req;
    crcfc_pkg::req_t head_req;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        if (wr_en)
        begin
            case (crcfc_pkg::reg_idx_t'(paddr[2]))
                crcfc_pkg::REG_MAGIC:   magic_next   = pwdata;
                crcfc_pkg::REG_VERSION: version_next = pwdata[15:0];
                default:                magic_next   = magic_reg;
            endcase
        end
    end

    always_comb
    begin
        case (crcfc_pkg::reg_idx_t'(paddr[2]))
            crcfc_pkg::REG_MAGIC:   prdata = magic_reg;
            crcfc_pkg::REG_VERSION: prdata = {16'd0, version_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= crcfc_pkg::MAGIC_RESET;
            version_reg <= crcfc_pkg::VERSION_RESET;
        end
        else
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
        end
    end

    crcfc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .data_byte      (in_ch.data_byte),
        .end_of_frame   (in_ch.end_of_frame),
        .expected_magic (magic_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_req          (front_req)
    );

    crcfc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_req  (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_req  (head_req)
    );

    crcfc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .q_req            (head_req),
        .q_pop            (q_pop),
        .expected_version (version_reg),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .frame_status     (out_ch.frame_status),
        .computed_crc     (out_ch.computed_crc)
    );

endmodule

@@ hdl/crcfc_front.sv @@
module crcfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                end_of_frame,
    input  logic [31:0]         expected_magic,
    input  logic                q_full,
    output logic                q_push,
    output crcfc_pkg::req_t     q_req
);

    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [7:0] want_byte;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    want_byte = expected_magic[31:24];
            2'd1:    want_byte = expected_magic[23:16];
            2'd2:    want_byte = expected_magic[15:8];
            default: want_byte = expected_magic[7:0];
        endcase
    end

    always_comb
    begin
        q_req.data        = data_byte;
        q_req.last        = end_of_frame;
        q_req.feed_crc    = (count_reg >= crcfc_pkg::MAGIC_LEN);
        q_req.magic_bad   = (count_reg < crcfc_pkg::MAGIC_LEN) && (data_byte != want_byte);
        q_req.ver_byte    = (count_reg == crcfc_pkg::VERSION_HI) ||
                            (count_reg == crcfc_pkg::VERSION_LO);
        // length after this byte is still below the minimum
        q_req.short_frame = (count_reg < (crcfc_pkg::MIN_FRAME_LEN - 4'd1));
    end

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            if (end_of_frame)
            begin
                count_next = 4'd0;
            end
            else if (count_reg < crcfc_pkg::MIN_FRAME_LEN)
            begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/crcfc_fifo.sv @@
module crcfc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crcfc_pkg::req_t     push_req,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output crcfc_pkg::req_t     head_req
);

    crcfc_pkg::req_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head_req  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ hdl/crcfc_back.sv @@
module crcfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  crcfc_pkg::req_t     q_req,
    output logic                q_pop,
    input  logic [15:0]         expected_version,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          frame_status,
    output logic [31:0]         computed_crc
);

    logic [31:0]        crc_reg;
    logic [31:0]        crc_next;
    logic [31:0]        trail_reg;
    logic [31:0]        trail_next;
    logic               magic_ok_reg;
    logic               magic_ok_next;
    logic [15:0]        ver_reg;
    logic [15:0]        ver_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    crcfc_pkg::status_t status_reg;
    crcfc_pkg::status_t status_next;
    logic [31:0]        crc_out_reg;
    logic [31:0]        crc_out_next;

    logic [31:0]        crc_upd;
    logic [31:0]        trail_upd;
    logic               magic_upd;
    logic [15:0]        ver_upd;
    logic [31:0]        crc_final;

    // output register frees when empty or being taken
    assign q_pop = q_not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        // oldest held byte leaves the delay line into the crc
        crc_upd   = q_req.feed_crc ? crcfc_pkg::crc_add_byte(crc_reg, trail_reg[31:24])
                                   : crc_reg;
        trail_upd = {trail_reg[23:0], q_req.data};
        magic_upd = magic_ok_reg && !q_req.magic_bad;
        ver_upd   = q_req.ver_byte ? {ver_reg[7:0], q_req.data} : ver_reg;
        crc_final = ~crc_upd;
    end

    always_comb
    begin
        crc_next       = crc_reg;
        trail_next     = trail_reg;
        magic_ok_next  = magic_ok_reg;
        ver_next       = ver_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        crc_out_next   = crc_out_reg;
        if (q_pop)
        begin
            if (q_req.last)
            begin
                crc_next       = crcfc_pkg::CRC_INIT;
                trail_next     = 32'd0;
                magic_ok_next  = 1'b1;
                ver_next       = 16'd0;
                out_valid_next = 1'b1;
                crc_out_next   = crc_final;
                if (q_req.short_frame)
                begin
                    status_next = crcfc_pkg::ST_TRUNCATED;
                end
                else if (!magic_upd)
                begin
                    status_next = crcfc_pkg::ST_BAD_MAGIC;
                end
                else if (trail_upd != crc_final)
                begin
                    status_next = crcfc_pkg::ST_BAD_CRC;
                end
                else if (ver_upd != expected_version)
                begin
                    status_next = crcfc_pkg::ST_BAD_VERSION;
                end
                else
                begin
                    status_next = crcfc_pkg::ST_OK;
                end
            end
            else
            begin
                crc_next      = crc_upd;
                trail_next    = trail_upd;
                magic_ok_next = magic_upd;
                ver_next      = ver_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= crcfc_pkg::CRC_INIT;
            trail_reg     <= 32'd0;
            magic_ok_reg  <= 1'b1;
            ver_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            trail_reg     <= trail_next;
            magic_ok_reg  <= magic_ok_next;
            ver_reg       <= ver_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        crc_out_reg <= crc_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = status_reg;
    assign computed_crc = crc_out_reg;

endmodule
